// ----- hw/rtl/mcrpm_pkg.sv -----
// mcrpm_pkg: shared types, codes and constants of the multi-channel rpm meter
// used by the subtractor, the config registers, the top level and the checker
// no dependencies
package mcrpm_pkg;

	localparam int CHANNELS_DEF = 5;
	localparam int NUM_LOCKOUTS = 5;
	localparam int TIME_W       = 64;
	localparam int REG_W        = 32;
	localparam int RPM_W        = 26;
	localparam int ADDR_W       = 5;

	localparam logic [RPM_W-1:0] RPM_NUM = 26'd60000000;

	localparam logic [NUM_LOCKOUTS-1:0][REG_W-1:0] LOCKOUT_RST =
		{32'd0, 32'd0, 32'd24000, 32'd24000, 32'd14000};
	localparam logic [REG_W-1:0] STALE_RST      = 32'd4000000;
	localparam logic [2:0]       MIN_ACTIVE_RST = 3'd2;
	localparam logic [2:0]       ZERO_GROUP_RST = 3'd3;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_PULSE = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_LOCKOUT0   = 3'd0,
		REG_LOCKOUT1   = 3'd1,
		REG_LOCKOUT2   = 3'd2,
		REG_LOCKOUT3   = 3'd3,
		REG_LOCKOUT4   = 3'd4,
		REG_STALE      = 3'd5,
		REG_MIN_ACTIVE = 3'd6,
		REG_ZERO_GROUP = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK,
		ST_P_AGE,
		ST_P_LOCK,
		ST_R_AGE,
		ST_R_STALE,
		ST_R_PER,
		ST_R_NZ,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [2:0] channel;
	} in_word_t;

	typedef struct packed {
		logic [RPM_W-1:0] rpm;
		logic             rotating;
		logic             any_zero;
	} out_word_t;

	typedef struct packed {
		logic [NUM_LOCKOUTS-1:0][REG_W-1:0] lockout;
		logic [REG_W-1:0]                   stale_timeout;
		logic [2:0]                         min_active;
		logic [2:0]                         zero_group_size;
	} cfg_t;

endpackage

// ----- hw/rtl/mcrpm_stream_if.sv -----
// mcrpm_stream_if: valid/ready channel carrying one word of type T
// payload types come from mcrpm_pkg
interface mcrpm_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/mcrpm_sub.sv -----
// mcrpm_sub: the shared 64-bit subtractor with borrow out
// depends on mcrpm_pkg
module mcrpm_sub (
	input  logic [mcrpm_pkg::TIME_W-1:0] a,
	input  logic [mcrpm_pkg::TIME_W-1:0] b,
	output logic [mcrpm_pkg::TIME_W-1:0] diff,
	output logic                         borrow
);
	import mcrpm_pkg::*;

	// borrow set means a < b
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};
endmodule

// ----- hw/rtl/mcrpm_cfg.sv -----
// mcrpm_cfg: APB-style configuration registers (lockouts, timeout, flag limits)
// depends on mcrpm_pkg
module mcrpm_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mcrpm_pkg::ADDR_W-1:0] paddr,
	input  logic [mcrpm_pkg::REG_W-1:0]  pwdata,
	output logic [mcrpm_pkg::REG_W-1:0]  prdata,
	output logic                         pready,
	output mcrpm_pkg::cfg_t              cfg
);
	import mcrpm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout         <= LOCKOUT_RST;
			cfg_q.stale_timeout   <= STALE_RST;
			cfg_q.min_active      <= MIN_ACTIVE_RST;
			cfg_q.zero_group_size <= ZERO_GROUP_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_LOCKOUT0:   cfg_q.lockout[0]         <= pwdata;
				REG_LOCKOUT1:   cfg_q.lockout[1]         <= pwdata;
				REG_LOCKOUT2:   cfg_q.lockout[2]         <= pwdata;
				REG_LOCKOUT3:   cfg_q.lockout[3]         <= pwdata;
				REG_LOCKOUT4:   cfg_q.lockout[4]         <= pwdata;
				REG_STALE:      cfg_q.stale_timeout      <= pwdata;
				REG_MIN_ACTIVE: cfg_q.min_active         <= pwdata[2:0];
				REG_ZERO_GROUP: cfg_q.zero_group_size    <= pwdata[2:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_LOCKOUT0:   prdata = cfg_q.lockout[0];
			REG_LOCKOUT1:   prdata = cfg_q.lockout[1];
			REG_LOCKOUT2:   prdata = cfg_q.lockout[2];
			REG_LOCKOUT3:   prdata = cfg_q.lockout[3];
			REG_LOCKOUT4:   prdata = cfg_q.lockout[4];
			REG_STALE:      prdata = cfg_q.stale_timeout;
			REG_MIN_ACTIVE: prdata = REG_W'(cfg_q.min_active);
			REG_ZERO_GROUP: prdata = REG_W'(cfg_q.zero_group_size);
		endcase
	end
endmodule

// ----- hw/rtl/multi_channel_rpm_meter.sv -----
// Multi-channel rpm meter: a 64-bit microsecond counter advanced by tick words, the last
// two accepted pulse times per channel, pulse lockout and an rpm read with rotation and
// zero flags. All time and rpm arithmetic goes through one shared 64-bit subtractor under
// a small sequencer, and the block takes one word at a time: a tick goes through ST_TICK,
// an in-range pulse through ST_P_AGE and ST_P_LOCK, an out-of-range pulse and the unused
// operation straight back to idle, and a read through ST_R_AGE, ST_R_STALE, ST_R_PER and
// ST_R_NZ once per channel, then 26 restoring-division steps when the read channel has a
// nonzero rpm, each step being one pass through the subtractor. A finished read waits in
// the output register, so the next word is taken while the result is still pending. The
// time stores are flip-flops cleared by reset; there is no clearing pass.
// depends on mcrpm_pkg, mcrpm_stream_if, mcrpm_sub and mcrpm_cfg
module multi_channel_rpm_meter #(
	parameter int CHANNELS = mcrpm_pkg::CHANNELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mcrpm_stream_if.sink                 req,
	mcrpm_stream_if.source               rsp,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mcrpm_pkg::ADDR_W-1:0] paddr,
	input  logic [mcrpm_pkg::REG_W-1:0]  pwdata,
	output logic [mcrpm_pkg::REG_W-1:0]  prdata,
	output logic                         pready
);
	import mcrpm_pkg::*;

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int ACT_W = $clog2(CHANNELS + 1);
	localparam int CMP_W = (ACT_W > 3) ? ACT_W : 3;
	localparam int DIV_W = $clog2(RPM_W);

	cfg_t cfg;

	mcrpm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t state_q, state_d;

	logic [TIME_W-1:0] time_now_q;
	logic [TIME_W-1:0] last_q [CHANNELS];
	logic [TIME_W-1:0] prev_q [CHANNELS];

	logic [2:0]        ch_q;
	logic [CH_W-1:0]   wk_q;
	logic [TIME_W-1:0] age_q;
	logic [TIME_W-1:0] per_q;
	logic              bad_q;
	logic [ACT_W-1:0]  active_q;
	logic              anyz_q;
	logic              sel_nz_q;
	logic [RPM_W-1:0]  dvs_q;
	logic [RPM_W-1:0]  rem_q;
	logic [RPM_W-1:0]  quo_q;
	logic [DIV_W-1:0]  div_cnt_q;
	logic              out_valid_q;
	out_word_t         out_q;

	logic              accept;
	logic              ch_ok;
	logic [CH_W-1:0]   ch_idx;
	logic [CH_W-1:0]   idx;
	logic [REG_W-1:0]  lock;
	logic [TIME_W-1:0] sub_a, sub_b, sub_diff;
	logic              sub_borrow;
	logic [RPM_W:0]    trial;
	logic              nz;
	logic              wk_sel;
	logic              wk_last;
	logic              sel_now;
	logic              out_free;

	mcrpm_sub u_sub (
		.a      (sub_a),
		.b      (sub_b),
		.diff   (sub_diff),
		.borrow (sub_borrow)
	);

	assign accept   = req.valid & req.ready;
	assign ch_ok    = {1'b0, ch_q} < 4'(CHANNELS);
	assign ch_idx   = ch_q[CH_W-1:0];
	assign idx      = (state_q == ST_P_AGE || state_q == ST_P_LOCK) ? ch_idx : wk_q;
	assign lock     = (ch_q < 3'(NUM_LOCKOUTS)) ? cfg.lockout[ch_q] : '0;
	assign trial    = {rem_q, quo_q[RPM_W-1]};
	// nonzero rpm: fresh, increasing times with a prior pulse, period within the numerator
	assign nz       = ~bad_q & ~sub_borrow;
	assign wk_sel   = ch_ok && (wk_q == ch_idx);
	assign wk_last  = (wk_q == CH_W'(CHANNELS - 1));
	assign sel_now  = wk_sel ? nz : sel_nz_q;
	assign out_free = ~out_valid_q | rsp.ready;

	// operand select for the shared subtractor
	always_comb begin
		unique case (state_q)
			ST_TICK: begin
				sub_a = time_now_q;
				sub_b = '1;
			end
			ST_P_AGE, ST_R_AGE: begin
				sub_a = time_now_q;
				sub_b = last_q[idx];
			end
			ST_P_LOCK: begin
				sub_a = age_q;
				sub_b = TIME_W'(lock);
			end
			ST_R_STALE: begin
				sub_a = TIME_W'(cfg.stale_timeout);
				sub_b = age_q;
			end
			ST_R_PER: begin
				sub_a = last_q[idx];
				sub_b = prev_q[idx];
			end
			ST_R_NZ: begin
				sub_a = TIME_W'(RPM_NUM);
				sub_b = per_q;
			end
			ST_DIV: begin
				sub_a = TIME_W'(trial);
				sub_b = TIME_W'(dvs_q);
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (op_t'(req.data.operation))
						OP_TICK:  state_d = ST_TICK;
						OP_PULSE: state_d = ({1'b0, req.data.channel} < 4'(CHANNELS)) ?
							ST_P_AGE : ST_IDLE;
						OP_READ:  state_d = ST_R_AGE;
						OP_NONE:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_TICK:    state_d = ST_IDLE;
			ST_P_AGE:   state_d = ST_P_LOCK;
			ST_P_LOCK:  state_d = ST_IDLE;
			ST_R_AGE:   state_d = ST_R_STALE;
			ST_R_STALE: state_d = ST_R_PER;
			ST_R_PER:   state_d = ST_R_NZ;
			ST_R_NZ: begin
				if (!wk_last) begin
					state_d = ST_R_AGE;
				end else begin
					state_d = sel_now ? ST_DIV : ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_W'(RPM_W - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		req.ready = (state_q == ST_IDLE);
		rsp.valid = out_valid_q;
		rsp.data  = out_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// time counter and per-channel pulse stores
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_now_q <= '0;
			for (int i = 0; i < CHANNELS; i++) begin
				last_q[i] <= '0;
				prev_q[i] <= '0;
			end
		end else begin
			if (state_q == ST_TICK) begin
				time_now_q <= sub_diff;
			end
			if (state_q == ST_P_LOCK && !sub_borrow) begin
				prev_q[ch_idx] <= last_q[ch_idx];
				last_q[ch_idx] <= time_now_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ch_q      <= req.data.channel;
				wk_q      <= '0;
				active_q  <= '0;
				anyz_q    <= 1'b0;
				sel_nz_q  <= 1'b0;
				rem_q     <= '0;
				quo_q     <= RPM_NUM;
				div_cnt_q <= '0;
			end
			ST_P_AGE, ST_R_AGE: age_q <= sub_diff;
			ST_R_STALE: bad_q <= sub_borrow | (prev_q[idx] == '0);
			ST_R_PER: begin
				per_q <= sub_diff;
				bad_q <= bad_q | sub_borrow | (sub_diff == '0);
			end
			ST_R_NZ: begin
				if (nz) begin
					active_q <= active_q + ACT_W'(1);
				end else if (3'(wk_q) < cfg.zero_group_size) begin
					anyz_q <= 1'b1;
				end
				if (wk_sel) begin
					sel_nz_q <= nz;
					dvs_q    <= per_q[RPM_W-1:0];
				end
				if (!wk_last) begin
					wk_q <= wk_q + CH_W'(1);
				end
			end
			ST_DIV: begin
				// restoring division, one quotient bit a step
				rem_q     <= sub_borrow ? trial[RPM_W-1:0] : sub_diff[RPM_W-1:0];
				quo_q     <= {quo_q[RPM_W-2:0], ~sub_borrow};
				div_cnt_q <= div_cnt_q + DIV_W'(1);
			end
			ST_DONE: begin
				if (out_free) begin
					out_q.rpm      <= sel_nz_q ? quo_q : '0;
					out_q.rotating <= CMP_W'(active_q) >= CMP_W'(cfg.min_active);
					out_q.any_zero <= anyz_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule

// ----- hw/rtl/mcrpm_chk.sv -----
// mcrpm_chk: port-level checks of the rpm meter, bound to the top level
// depends on mcrpm_pkg
module mcrpm_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic [1:0]                  req_op,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [mcrpm_pkg::RPM_W-1:0] rsp_rpm,
	input logic                        rsp_rotating,
	input logic                        rsp_any_zero
);
	import mcrpm_pkg::*;

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rpm) &&
			$stable(rsp_rotating) && $stable(rsp_any_zero))
		else $error("result word changed while stalled");

	// rpm never exceeds the numerator
	a_rpm_max: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_rpm <= RPM_NUM)
		else $error("rpm above limit");

	// a tick or read word keeps the sequencer busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_op == OP_TICK || req_op == OP_READ) |=> !req_ready)
		else $error("ready right after a word was taken");

	// a new result comes out of the busy sequencer
	a_rsp_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result appeared while idle");
endmodule

bind multi_channel_rpm_meter mcrpm_chk u_mcrpm_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_op       (req.data.operation),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_rpm      (rsp.data.rpm),
	.rsp_rotating (rsp.data.rotating),
	.rsp_any_zero (rsp.data.any_zero)
);

// ----- tb/sv/testbench.sv -----
// testbench for multi_channel_rpm_meter: directed and random tick, pulse and read words,
// with every read checked against a scoreboard that tracks time, pulse stores and registers
// depends on mcrpm_pkg, mcrpm_stream_if and the rtl of the meter
`timescale 1ns / 1ps

module testbench;
	import mcrpm_pkg::*;

	class rpm_scoreboard;
		logic [TIME_W-1:0] now_us;
		logic [TIME_W-1:0] last_pulse [CHANNELS_DEF];
		logic [TIME_W-1:0] prev_pulse [CHANNELS_DEF];
		logic [REG_W-1:0]  lockout [NUM_LOCKOUTS];
		logic [REG_W-1:0]  stale_limit;
		logic [2:0]        min_active;
		logic [2:0]        zero_group;
		out_word_t         expected_reads [$];
		int                errors;
		int                reads_checked;

		function new();
			now_us = '0;
			for (int i = 0; i < CHANNELS_DEF; i++) begin
				last_pulse[i] = '0;
				prev_pulse[i] = '0;
			end
			for (int i = 0; i < NUM_LOCKOUTS; i++)
				lockout[i] = LOCKOUT_RST[i];
			stale_limit = STALE_RST;
			min_active = MIN_ACTIVE_RST;
			zero_group = ZERO_GROUP_RST;
			errors = 0;
			reads_checked = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [REG_W-1:0] value);
			case (idx)
				REG_STALE:      stale_limit = value;
				REG_MIN_ACTIVE: min_active = value[2:0];
				REG_ZERO_GROUP: zero_group = value[2:0];
				default:        lockout[int'(idx)] = value;
			endcase
		endfunction

		function logic [TIME_W-1:0] speed_of(int ch);
			logic [TIME_W-1:0] t_prev;
			logic [TIME_W-1:0] t_last;
			if (ch >= CHANNELS_DEF)
				return '0;
			t_prev = prev_pulse[ch];
			t_last = last_pulse[ch];
			if (now_us - t_last > {32'd0, stale_limit})
				return '0;
			if (t_prev == 0 || t_last <= t_prev)
				return '0;
			return 64'(RPM_NUM) / (t_last - t_prev);
		endfunction

		function void note_input(in_word_t w);
			int               ch;
			int               active;
			logic             zero_seen;
			logic [REG_W-1:0] lock;
			logic [TIME_W-1:0] speed;
			out_word_t        r;
			ch = int'(w.channel);
			case (op_t'(w.operation))
				OP_TICK: now_us = now_us + 1;
				OP_PULSE: begin
					if (ch < CHANNELS_DEF) begin
						// channels past the lockout registers have no lockout
						lock = (ch < NUM_LOCKOUTS) ? lockout[ch] : '0;
						if (now_us - last_pulse[ch] >= {32'd0, lock}) begin
							prev_pulse[ch] = last_pulse[ch];
							last_pulse[ch] = now_us;
						end
					end
				end
				OP_READ: begin
					active = 0;
					zero_seen = 1'b0;
					for (int i = 0; i < CHANNELS_DEF; i++) begin
						if (speed_of(i) != 0)
							active++;
						else if (i < zero_group)
							zero_seen = 1'b1;
					end
					speed = speed_of(ch);
					r.rpm = speed[RPM_W-1:0];
					r.rotating = (active >= min_active);
					r.any_zero = zero_seen;
					expected_reads.push_back(r);
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(out_word_t got);
			out_word_t want;
			if (expected_reads.size() == 0) begin
				report("result word with no read pending");
				return;
			end
			want = expected_reads.pop_front();
			reads_checked++;
			if (got.rpm !== want.rpm)
				report($sformatf("rpm %0d, predicted %0d", got.rpm, want.rpm));
			if (got.rotating !== want.rotating)
				report($sformatf("rotating %b, predicted %b", got.rotating, want.rotating));
			if (got.any_zero !== want.any_zero)
				report($sformatf("any_zero %b, predicted %b", got.any_zero, want.any_zero));
		endtask
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [REG_W-1:0]  pwdata;
	logic [REG_W-1:0]  prdata;
	logic              pready;

	bit feed_gaps = 1'b0;
	bit sink_stalls = 1'b0;
	int items_sent = 0;

	rpm_scoreboard sb = new();

	mcrpm_stream_if #(.T(in_word_t))  req_if ();
	mcrpm_stream_if #(.T(out_word_t)) rsp_if ();

	multi_channel_rpm_meter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_if),
		.rsp     (rsp_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d reads outstanding", sb.expected_reads.size());
		$display("testbench: errors");
		$finish;
	end

	// handshake monitor, sees values from before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				sb.note_input(req_if.data);
			if (rsp_if.valid && rsp_if.ready)
				sb.check_result(rsp_if.data);
		end
	end

	initial begin
		rsp_if.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (sink_stalls && $urandom_range(0, 9) == 0) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				rsp_if.ready <= 1'b1;
			end
		end
	end

	task automatic idle_feed(int cycles);
		req_if.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic send_word(op_t op, logic [2:0] ch);
		in_word_t w;
		if (feed_gaps && $urandom_range(0, 6) == 0)
			idle_feed($urandom_range(1, 11));
		w.operation = op;
		w.channel = ch;
		req_if.valid <= 1'b1;
		req_if.data <= w;
		do @(posedge clk); while (!req_if.ready);
		if (op != OP_NONE && !(op == OP_PULSE && ch >= CHANNELS_DEF))
			items_sent++;
	endtask

	// wait out every pending read and any tick or pulse still in flight
	task automatic drain();
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_reads.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [REG_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic set_lockouts(logic [REG_W-1:0] l0, logic [REG_W-1:0] l1,
			logic [REG_W-1:0] l2, logic [REG_W-1:0] l3, logic [REG_W-1:0] l4);
		write_reg(REG_LOCKOUT0, l0);
		write_reg(REG_LOCKOUT1, l1);
		write_reg(REG_LOCKOUT2, l2);
		write_reg(REG_LOCKOUT3, l3);
		write_reg(REG_LOCKOUT4, l4);
	endtask

	task automatic set_flags(logic [REG_W-1:0] stale, logic [2:0] min_act, logic [2:0] group);
		write_reg(REG_STALE, stale);
		write_reg(REG_MIN_ACTIVE, {29'd0, min_act});
		write_reg(REG_ZERO_GROUP, {29'd0, group});
	endtask

	// mostly ticks and in-range pulses so periods build up, with reads and some noise
	task automatic random_words(int count);
		int done;
		int pick;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				send_word(OP_TICK, 3'($urandom_range(0, 7)));
			else if (pick < 75)
				send_word(OP_PULSE, 3'($urandom_range(0, CHANNELS_DEF - 1)));
			else if (pick < 80)
				send_word(OP_PULSE, 3'($urandom_range(CHANNELS_DEF, 7)));
			else if (pick < 97)
				send_word(OP_READ, 3'($urandom_range(0, 7)));
			else
				send_word(OP_NONE, 3'($urandom_range(0, 7)));
			if (pick < 75 || (pick >= 80 && pick < 97))
				done++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		req_if.valid <= 1'b0;
		req_if.data <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first pulse at time zero, period of one, equal times, lockout
		// that never opens, out-of-range channels and the unused operation
		set_lockouts(32'd0, 32'd0, 32'd2, 32'hFFFF_FFFF, 32'd0);
		set_flags(32'hFFFF_FFFF, 3'd0, 3'd7);
		send_word(OP_READ, 3'd0);
		send_word(OP_PULSE, 3'd0);
		send_word(OP_PULSE, 3'd3);
		send_word(OP_TICK, 3'd0);
		send_word(OP_PULSE, 3'd0);
		send_word(OP_READ, 3'd0);
		send_word(OP_TICK, 3'd7);
		send_word(OP_PULSE, 3'd0);
		send_word(OP_READ, 3'd0);
		send_word(OP_PULSE, 3'd0);
		send_word(OP_READ, 3'd0);
		send_word(OP_PULSE, 3'd2);
		send_word(OP_PULSE, 3'd2);
		send_word(OP_TICK, 3'd0);
		send_word(OP_TICK, 3'd0);
		send_word(OP_PULSE, 3'd2);
		send_word(OP_PULSE, 3'd1);
		send_word(OP_PULSE, 3'd4);
		send_word(OP_PULSE, 3'd5);
		send_word(OP_PULSE, 3'd7);
		send_word(OP_NONE, 3'd6);
		send_word(OP_READ, 3'd7);
		send_word(OP_READ, 3'd5);
		send_word(OP_READ, 3'd2);
		drain();

		feed_gaps = 1'b1;
		sink_stalls = 1'b1;
		set_lockouts($urandom_range(0, 8), $urandom_range(0, 8), $urandom_range(0, 8),
			$urandom_range(0, 8), $urandom_range(0, 8));
		set_flags(32'hFFFF_FFFF, 3'd1, 3'd3);
		random_words(190);
		drain();

		// zero stale timeout: only a read right after a pulse sees speed
		sink_stalls = 1'b0;
		set_lockouts(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
		set_flags(32'd0, 3'd5, 3'd5);
		random_words(190);
		drain();

		feed_gaps = 1'b0;
		sink_stalls = 1'b1;
		set_lockouts(32'd0, 32'hFFFF_FFFF, $urandom_range(0, 20), 32'd14000,
			$urandom_range(0, 20));
		set_flags($urandom_range(10, 60), 3'd7, 3'd0);
		random_words(190);
		drain();

		feed_gaps = 1'b1;
		set_lockouts($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 15), $urandom_range(0, 15));
		set_flags($urandom_range(20, 300), 3'($urandom_range(0, 7)),
			3'($urandom_range(0, 7)));
		random_words(90);
		drain();
		random_words(100);
		drain();

		feed_gaps = 1'b0;
		sink_stalls = 1'b0;
		set_lockouts($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
			$urandom_range(0, 4), $urandom_range(0, 4));
		set_flags(32'hFFFF_FFFF, 3'd2, 3'd6);
		random_words(190);
		drain();

		$display("covered %0d tick, pulse and read words across six register settings",
			items_sent);
		$display("%0d reads compared, %0d mismatches", sb.reads_checked, sb.errors);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/mcrpm_pkg.sv
hw/rtl/mcrpm_stream_if.sv
hw/rtl/mcrpm_sub.sv
hw/rtl/mcrpm_cfg.sv
hw/rtl/multi_channel_rpm_meter.sv
hw/rtl/mcrpm_chk.sv
tb/sv/testbench.sv
